[src/tbs_pkg.sv]
package tbs_pkg;

	// coordinate width used by the bounding box
	localparam int COORD_BITS  = 10;
	// fixed field widths
	localparam int POINT_BITS  = 10;
	localparam int CENTRE_BITS = 10;
	localparam int AREA_BITS   = 20;
	localparam int CMD_BITS    = 3;
	localparam int REG_BITS    = 20;
	localparam int WIDTH_BITS  = 11;
	localparam int COUNT_BITS  = 21;
	localparam int INDEX_BITS  = 3;

	// derived widths
	localparam int PROD_BITS  = 2 * COORD_BITS;
	localparam int AREA_CMP_BITS = (PROD_BITS > REG_BITS) ? PROD_BITS : REG_BITS;
	localparam int THIRD_BITS = WIDTH_BITS + 1;
	localparam int POS_CMP_BITS = (THIRD_BITS > COORD_BITS) ? THIRD_BITS : COORD_BITS;
	localparam int IN_DATA_BITS  = ((2 * POINT_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = CMD_BITS + AREA_BITS + CENTRE_BITS;
	localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_FIELD_BITS;

	// divide by three as a multiply by the reciprocal, exact below 2**16
	localparam int DIV3_SHIFT = 17;
	localparam logic [DIV3_SHIFT-1:0] DIV3_MUL = 17'd43691;

	// register reset values
	localparam logic [REG_BITS-1:0]   MIN_POINTS_RST  = 20'd1200;
	localparam logic [REG_BITS-1:0]   BACK_AREA_RST   = 20'd40000;
	localparam logic [REG_BITS-1:0]   STOP_AREA_RST   = 20'd28000;
	localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RST = 11'd320;

	typedef enum logic [INDEX_BITS-1:0] {
		REG_AUTO_ENABLE = 3'd0,
		REG_MIN_POINTS  = 3'd1,
		REG_BACK_AREA   = 3'd2,
		REG_STOP_AREA   = 3'd3,
		REG_IMAGE_WIDTH = 3'd4
	} reg_idx_t;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_BACK    = 3'd0,
		CMD_STOP    = 3'd1,
		CMD_LEFT    = 3'd2,
		CMD_RIGHT   = 3'd3,
		CMD_FORWARD = 3'd4
	} cmd_t;

	// accepted input item
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  has_point;
		logic                  eof;
	} in_item_t;

	// finished frame box
	typedef struct packed {
		logic [COORD_BITS-1:0] min_x;
		logic [COORD_BITS-1:0] max_x;
		logic [COORD_BITS-1:0] min_y;
		logic [COORD_BITS-1:0] max_y;
		logic                  hit;
	} box_t;

	// area and centre of a frame
	typedef struct packed {
		logic [PROD_BITS-1:0]  area;
		logic [COORD_BITS-1:0] centre;
		logic                  hit;
	} geom_t;

	// result item
	typedef struct packed {
		logic [CENTRE_BITS-1:0] centre_x;
		logic [AREA_BITS-1:0]   box_area;
		cmd_t                   command;
	} result_t;

	// floor(n / 3)
	function automatic logic [THIRD_BITS-1:0] div3(input logic [THIRD_BITS-1:0] n);
		logic [THIRD_BITS+DIV3_SHIFT-1:0] p;
		p = {{DIV3_SHIFT{1'b0}}, n} * {{THIRD_BITS{1'b0}}, DIV3_MUL};
		return p[THIRD_BITS+DIV3_SHIFT-1:DIV3_SHIFT];
	endfunction

endpackage

[src/target_bbox_steering.sv]
// target_bbox_steering: bounding box and steering command per frame
// throughput: one item per cycle; the input stalls only while a frame-end item sits in
// the input register behind a full command pipeline
// path: a frame-end item passes the input register, box stage, area multiply and decision
// register before its command appears on m_tdata
// reset: arst_n clears box, point count, turn direction, pipeline valids, sets registers
module target_bbox_steering (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [tbs_pkg::INDEX_BITS-1:0]       cfg_index,
	input  logic [tbs_pkg::REG_BITS-1:0]         cfg_wdata,
	// pixel items
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [tbs_pkg::IN_DATA_BITS-1:0]     s_tdata,  // point_x, point_y, zero pad
	input  logic                                 s_tuser,  // has_point
	input  logic                                 s_tlast,  // end_of_frame
	// command items
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [tbs_pkg::OUT_DATA_BITS-1:0]    m_tdata   // command, box_area, centre_x, zero pad
);
	import tbs_pkg::*;

	localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [AREA_BITS-1:0]  AREA_MAX  = {AREA_BITS{1'b1}};

	// configuration registers
	logic                  auto_enable_q;
	logic [REG_BITS-1:0]   min_points_q;
	logic [REG_BITS-1:0]   back_area_q;
	logic [REG_BITS-1:0]   stop_area_q;
	logic [WIDTH_BITS-1:0] image_width_q;
	logic [THIRD_BITS-1:0] third_q;
	logic [THIRD_BITS-1:0] two_third_q;

	// frame state
	logic [COORD_BITS-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  last_left_q;

	// pipeline
	logic     s1_v_q, s2_v_q, s3_v_q, out_v_q;
	in_item_t s1_q;
	box_t     s2_q;
	geom_t    s3_q;
	result_t  out_q;

	logic out_adv, s3_adv, s2_adv, s1_adv;

	// stage handshakes: a stage moves when empty or when its successor moves
	always_comb begin
		out_adv = !out_v_q || m_tready;
		s3_adv  = !s3_v_q || out_adv;
		s2_adv  = !s2_v_q || s3_adv;
		s1_adv  = !s1_v_q || !s1_q.eof || !auto_enable_q || s2_adv;
	end

	assign s_tready = s1_adv;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, out_q};

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_enable_q <= 1'b0;
			min_points_q  <= MIN_POINTS_RST;
			back_area_q   <= BACK_AREA_RST;
			stop_area_q   <= STOP_AREA_RST;
			image_width_q <= IMAGE_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_AUTO_ENABLE: auto_enable_q <= cfg_wdata[0];
				REG_MIN_POINTS:  min_points_q  <= cfg_wdata;
				REG_BACK_AREA:   back_area_q   <= cfg_wdata;
				REG_STOP_AREA:   stop_area_q   <= cfg_wdata;
				REG_IMAGE_WIDTH: image_width_q <= cfg_wdata[WIDTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	// image thirds, registered from the width register
	always_ff @(posedge clk) begin
		third_q     <= div3({1'b0, image_width_q});
		two_third_q <= div3({image_width_q, 1'b0});
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s1_adv) begin
			s1_v_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			s1_q.x         <= COORD_BITS'(s_tdata[POINT_BITS-1:0]);
			s1_q.y         <= COORD_BITS'(s_tdata[2*POINT_BITS-1:POINT_BITS]);
			s1_q.has_point <= s_tuser;
			s1_q.eof       <= s_tlast;
		end
	end

	// box and count with the current pixel folded in
	logic [COORD_BITS-1:0] nmin_x, nmax_x, nmin_y, nmax_y;
	logic [COUNT_BITS-1:0] ncount;
	logic                  nhit;

	always_comb begin
		nmin_x = min_x_q;
		nmax_x = max_x_q;
		nmin_y = min_y_q;
		nmax_y = max_y_q;
		ncount = count_q;
		if (s1_q.has_point) begin
			if (s1_q.x < min_x_q) nmin_x = s1_q.x;
			if (s1_q.x > max_x_q) nmax_x = s1_q.x;
			if (s1_q.y < min_y_q) nmin_y = s1_q.y;
			if (s1_q.y > max_y_q) nmax_y = s1_q.y;
			if (count_q != COUNT_MAX) ncount = count_q + 1'b1;
		end
		nhit = ncount > {1'b0, min_points_q};
	end

	// frame state update, cleared on every frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= COORD_MAX;
			max_x_q <= '0;
			min_y_q <= COORD_MAX;
			max_y_q <= '0;
			count_q <= '0;
		end else if (s1_v_q && s1_adv) begin
			if (s1_q.eof) begin
				min_x_q <= COORD_MAX;
				max_x_q <= '0;
				min_y_q <= COORD_MAX;
				max_y_q <= '0;
				count_q <= '0;
			end else begin
				min_x_q <= nmin_x;
				max_x_q <= nmax_x;
				min_y_q <= nmin_y;
				max_y_q <= nmax_y;
				count_q <= ncount;
			end
		end
	end

	// finished box, only when a command is due
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (s2_adv) begin
			s2_v_q <= s1_v_q && s1_q.eof && auto_enable_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			s2_q.min_x <= nmin_x;
			s2_q.max_x <= nmax_x;
			s2_q.min_y <= nmin_y;
			s2_q.max_y <= nmax_y;
			s2_q.hit   <= nhit;
		end
	end

	// width times height and box centre
	logic [COORD_BITS-1:0] box_w, box_h;
	logic [COORD_BITS:0]   centre_sum;

	always_comb begin
		box_w      = s2_q.max_x - s2_q.min_x;
		box_h      = s2_q.max_y - s2_q.min_y;
		centre_sum = {1'b0, s2_q.min_x} + {1'b0, s2_q.max_x};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_q <= 1'b0;
		end else if (s3_adv) begin
			s3_v_q <= s2_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_adv) begin
			s3_q.area   <= {{COORD_BITS{1'b0}}, box_w} * {{COORD_BITS{1'b0}}, box_h};
			s3_q.centre <= centre_sum[COORD_BITS:1];
			s3_q.hit    <= s2_q.hit;
		end
	end

	// steering decision
	logic [AREA_CMP_BITS-1:0] area_cmp;
	logic [POS_CMP_BITS-1:0]  centre_cmp;
	cmd_t                     cmd_d;
	logic                     left_d;

	always_comb begin
		area_cmp   = AREA_CMP_BITS'(s3_q.area);
		centre_cmp = POS_CMP_BITS'(s3_q.centre);
		left_d     = last_left_q;
		if (!s3_q.hit) begin
			cmd_d = last_left_q ? CMD_LEFT : CMD_RIGHT;
		end else if (area_cmp > AREA_CMP_BITS'(back_area_q)) begin
			cmd_d = CMD_BACK;
		end else if (area_cmp > AREA_CMP_BITS'(stop_area_q)) begin
			cmd_d = CMD_STOP;
		end else if (centre_cmp < POS_CMP_BITS'(third_q)) begin
			cmd_d  = CMD_LEFT;
			left_d = 1'b1;
		end else if (centre_cmp > POS_CMP_BITS'(two_third_q)) begin
			cmd_d  = CMD_RIGHT;
			left_d = 1'b0;
		end else begin
			cmd_d = CMD_FORWARD;
		end
	end

	// result register and turn memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q     <= 1'b0;
			last_left_q <= 1'b0;
		end else if (out_adv) begin
			out_v_q <= s3_v_q;
			if (s3_v_q) last_left_q <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			out_q.command <= cmd_d;
			if (!s3_q.hit) begin
				out_q.box_area <= '0;
				out_q.centre_x <= '0;
			end else begin
				out_q.box_area <= (area_cmp > AREA_CMP_BITS'(AREA_MAX)) ? AREA_MAX
					: AREA_BITS'(s3_q.area);
				out_q.centre_x <= CENTRE_BITS'(s3_q.centre);
			end
		end
	end

endmodule
